// ===== src/nlp_pkg.sv =====
package nlp_pkg;

   // Default configuration of the predictor.
   localparam int DEF_MAX_FEATURES = 512;
   localparam int DEF_FRAC_BITS    = 16;

   // Fixed field widths.
   localparam int DATA_W  = 32;
   localparam int SCALE_W = 31;
   localparam int INDEX_W = 9;
   localparam int PRED_W  = 18;
   localparam int USED_W  = 10;

   // Arithmetic widths: product of weight and centred feature, clamped term
   // and saturating accumulator.
   localparam int PROD_W    = 64;
   localparam int TERM_W    = 50;
   localparam int SUM_W     = 48;
   localparam int DIV_STEPS = PROD_W;

   // Word kinds on the request channel.
   localparam logic KIND_FEATURE = 1'b0;
   localparam logic KIND_LOAD    = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_write;
      logic capture;
      logic fetch;
      logic mul;
      logic div_start;
      logic make_term;
      logic accumulate;
      logic emit;
   } nlp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_range;
      logic last;
      logic div_done;
      logic out_free;
   } nlp_sts_type;

endpackage

// ===== src/nlp_divider.sv =====
module nlp_divider
   import nlp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [PROD_W-1:0]   dividend,
   input  logic [SCALE_W-1:0]  divisor,
   output logic                done,
   output logic [PROD_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(DIV_STEPS + 1);

   logic                busy_ff,  busy_in;
   logic                done_ff,  done_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SCALE_W-1:0]  rem_ff,   rem_in;
   logic [PROD_W-1:0]   quo_ff,   quo_in;
   logic [SCALE_W-1:0]  dvs_ff,   dvs_in;
   logic [SCALE_W:0]    shifted;
   logic [SCALE_W:0]    trial;

   // One restoring step: bring down the next dividend bit and try a subtract.
   assign shifted = {rem_ff, quo_ff[PROD_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(DIV_STEPS);
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = trial[SCALE_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[SCALE_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b0};
         end
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is cleared by reset; the working registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/nlp_datapath.sv =====
module nlp_datapath
   import nlp_pkg::*;
#(
   parameter int MAX_FEATURES = DEF_MAX_FEATURES,
   parameter int FRAC_BITS    = DEF_FRAC_BITS
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  nlp_cmd_type               cmd,
   output nlp_sts_type               sts,
   input  logic [INDEX_W-1:0]        req_entry_index,
   input  logic signed [DATA_W-1:0]  req_feature_value,
   input  logic signed [DATA_W-1:0]  req_load_weight,
   input  logic signed [DATA_W-1:0]  req_load_mean,
   input  logic [SCALE_W-1:0]        req_load_scale,
   input  logic                      req_last,
   input  logic signed [DATA_W-1:0]  bias,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [PRED_W-1:0]  rsp_prediction,
   output logic [USED_W-1:0]         rsp_features_used,
   output logic                      rsp_too_many,
   output logic                      rsp_saturated
);

   localparam int ADDR_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int POS_W  = $clog2(MAX_FEATURES + 1);

   localparam logic [SCALE_W-1:0]      ONE_SCALE    = SCALE_W'(1) << FRAC_BITS;
   localparam logic [PROD_W-1:0]       TERM_POS_MAX = (PROD_W'(1) << SUM_W) - PROD_W'(2);
   localparam logic [PROD_W-1:0]       TERM_NEG_MAG = PROD_W'(1) << SUM_W;
   localparam logic signed [SUM_W-1:0] SUM_MAX      = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN      = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] PRED_ONE     = SUM_W'(1) << FRAC_BITS;
   localparam logic signed [SUM_W-1:0] PRED_NEG     = -PRED_ONE;

   typedef struct packed {
      logic signed [DATA_W-1:0] weight;
      logic signed [DATA_W-1:0] mean;
      logic [SCALE_W-1:0]       scale;
   } coef_type;

   coef_type coef_mem [MAX_FEATURES];
   coef_type coef_rd_ff;

   logic signed [DATA_W-1:0]  x_ff;
   logic                      last_ff;
   logic signed [DATA_W:0]    diff_ff,    diff_in;
   logic [SCALE_W-1:0]        divisor_ff, divisor_in;
   logic signed [PROD_W-1:0]  prod_ff,    prod_in;
   logic                      neg_ff;
   logic [PROD_W-1:0]         dividend;
   logic [PROD_W-1:0]         quotient;
   logic                      div_done;
   logic [PROD_W-1:0]         mag;
   logic signed [TERM_W-1:0]  term_ff,    term_in;

   logic signed [SUM_W-1:0]   sum_ff,     sum_in;
   logic [POS_W-1:0]          pos_ff,     pos_in;
   logic                      ovf_ff,     ovf_in;
   logic                      sat_ff,     sat_in;
   logic signed [SUM_W-1:0]   base;
   logic signed [SUM_W+2:0]   sum_wide;
   logic signed [SUM_W-1:0]   pred;
   logic                      in_range;
   logic                      load_ok;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [PRED_W-1:0]  pred_ff;
   logic [USED_W-1:0]         used_ff;
   logic                      too_many_ff;
   logic                      saturated_ff;

   assign in_range = pos_ff < POS_W'(MAX_FEATURES);
   assign load_ok  = int'(req_entry_index) < MAX_FEATURES;

   // Coefficient table: written by load words, read at the current position.
   always_ff @(posedge clock) begin
      if (cmd.load_write && load_ok) begin
         coef_mem[ADDR_W'(req_entry_index)] <= '{weight: req_load_weight,
                                                mean:   req_load_mean,
                                                scale:  req_load_scale};
      end
      if (cmd.capture && in_range) begin
         coef_rd_ff <= coef_mem[ADDR_W'(pos_ff)];
      end
   end

   // Centre the feature and pick the divisor; a zero scale counts as one.
   assign diff_in    = {x_ff[DATA_W-1], x_ff} - {coef_rd_ff.mean[DATA_W-1], coef_rd_ff.mean};
   assign divisor_in = (coef_rd_ff.scale == '0) ? ONE_SCALE : coef_rd_ff.scale;
   assign prod_in    = coef_rd_ff.weight * diff_ff;
   assign dividend   = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff    <= req_feature_value;
         last_ff <= req_last;
      end
      if (cmd.fetch) begin
         diff_ff    <= diff_in;
         divisor_ff <= divisor_in;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.div_start) begin
         neg_ff <= prod_ff[PROD_W-1];
      end
      if (cmd.make_term) begin
         term_ff <= term_in;
      end
   end

   nlp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Restore the sign of the truncated quotient and clamp it to twice the sum range.
   always_comb begin
      if (neg_ff) begin
         mag     = (quotient > TERM_NEG_MAG) ? TERM_NEG_MAG : quotient;
         term_in = -$signed(TERM_W'(mag));
      end else begin
         mag     = (quotient > TERM_POS_MAX) ? TERM_POS_MAX : quotient;
         term_in = $signed(TERM_W'(mag));
      end
   end

   // Saturating accumulate; the bias seeds the sum on the first feature.
   assign base     = (pos_ff == '0 && !ovf_ff) ? SUM_W'(bias) : sum_ff;
   assign sum_wide = base + term_ff;

   always_comb begin
      sum_in = sum_ff;
      pos_in = pos_ff;
      ovf_in = ovf_ff;
      sat_in = sat_ff;
      if (cmd.emit) begin
         sum_in = '0;
         pos_in = '0;
         ovf_in = 1'b0;
         sat_in = 1'b0;
      end else if (cmd.accumulate) begin
         if (in_range) begin
            if (sum_wide > SUM_MAX) begin
               sum_in = SUM_MAX;
               sat_in = 1'b1;
            end else if (sum_wide < SUM_MIN) begin
               sum_in = SUM_MIN;
               sat_in = 1'b1;
            end else begin
               sum_in = SUM_W'(sum_wide);
            end
            pos_in = pos_ff + POS_W'(1);
         end else begin
            sum_in = base;
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         pos_ff <= '0;
         ovf_ff <= 1'b0;
         sat_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         pos_ff <= pos_in;
         ovf_ff <= ovf_in;
         sat_ff <= sat_in;
      end
   end

   // Output register: clamp to plus or minus one and hold until taken.
   assign pred = (sum_ff > PRED_ONE) ? PRED_ONE :
                 (sum_ff < PRED_NEG) ? PRED_NEG : sum_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         pred_ff      <= PRED_W'(pred);
         used_ff      <= USED_W'(pos_ff);
         too_many_ff  <= ovf_ff;
         saturated_ff <= sat_ff;
      end
   end

   assign sts.in_range = in_range;
   assign sts.last     = last_ff;
   assign sts.div_done = div_done;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_prediction    = pred_ff;
   assign rsp_features_used = used_ff;
   assign rsp_too_many      = too_many_ff;
   assign rsp_saturated     = saturated_ff;

`ifndef SYNTHESIS
   // A new result is only loaded when the previous one has been taken.
   assert property (@(posedge clock) disable iff (reset) cmd.emit |-> sts.out_free)
      else $error("result loaded over an untaken word");

   // Emitting a result clears the per-vector position.
   assert property (@(posedge clock) disable iff (reset) cmd.emit |=> (pos_ff == '0))
      else $error("position not cleared after result");

   // The position never runs past the table size.
   assert property (@(posedge clock) disable iff (reset) pos_ff <= POS_W'(MAX_FEATURES))
      else $error("position beyond table size");
`endif

endmodule

// ===== src/nlp_ctrl.sv =====
module nlp_ctrl
   import nlp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_kind,
   output logic         req_ready,
   input  nlp_sts_type  sts,
   output nlp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_MUL,
      S_START,
      S_DIV,
      S_TERM,
      S_ACC,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // Command decode from the current state.
   always_comb begin
      cmd            = '0;
      cmd.load_write = accept && (req_kind == KIND_LOAD);
      cmd.capture    = accept && (req_kind == KIND_FEATURE);
      cmd.fetch      = (state_ff == S_FETCH);
      cmd.mul        = (state_ff == S_MUL);
      cmd.div_start  = (state_ff == S_START);
      cmd.make_term  = (state_ff == S_TERM);
      cmd.accumulate = (state_ff == S_ACC);
      cmd.emit       = (state_ff == S_EMIT) && sts.out_free;
   end

   // Sequence one feature word through fetch, multiply, divide and accumulate (beyond the table: accumulate only).
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.capture) begin
               state_in = sts.in_range ? S_FETCH : S_ACC;
            end
         end
         S_FETCH: state_in = S_MUL;
         S_MUL:   state_in = S_START;
         S_START: state_in = S_DIV;
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_TERM;
            end
         end
         S_TERM:  state_in = S_ACC;
         S_ACC:   state_in = sts.last ? S_EMIT : S_IDLE;
         S_EMIT: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // Only features that fall inside the table go through the term path.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH) |-> sts.in_range)
      else $error("term path entered for a feature beyond the table");

   // The divider only finishes while the sequencer is waiting for it.
   assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide state");

   // A load word is taken while idle and leaves the sequencer idle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_write |=> (state_ff == S_IDLE))
      else $error("sequencer left idle on a load word");
`endif

endmodule

// ===== src/normalized_linear_predictor.sv =====
// A load is taken while idle and leaves the block idle; a feature beyond the table size goes to
// accumulate alone. A feature inside the table goes through fetch, multiply, start, divide, term
// and accumulate; its divider is bit-serial and retires one quotient bit per cycle over a
// 64-bit dividend. The last feature then waits in emit until the output register is free.
// One word is in flight at a time; a finished result waits in an output register.
// Synchronous active-high reset clears the sum, position, flags and the bias register;
// the coefficient table is not cleared and holds nothing useful until loaded.
module normalized_linear_predictor
   import nlp_pkg::*;
#(
   parameter int MAX_FEATURES = DEF_MAX_FEATURES,
   parameter int FRAC_BITS    = DEF_FRAC_BITS
)
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_kind,
   input  logic [INDEX_W-1:0]        req_entry_index,
   input  logic signed [DATA_W-1:0]  req_feature_value,
   input  logic signed [DATA_W-1:0]  req_load_weight,
   input  logic signed [DATA_W-1:0]  req_load_mean,
   input  logic [SCALE_W-1:0]        req_load_scale,
   input  logic                      req_last,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [PRED_W-1:0]  rsp_prediction,
   output logic [USED_W-1:0]         rsp_features_used,
   output logic                      rsp_too_many,
   output logic                      rsp_saturated,

   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [1:0]                csr_paddr,
   input  logic [DATA_W-1:0]         csr_pwdata,
   output logic [DATA_W-1:0]         csr_prdata,
   output logic                      csr_pready
);

   localparam logic [1:0] BIAS_ADDR = 2'd0;

   logic signed [DATA_W-1:0] bias_ff, bias_in;
   logic                     csr_write;
   nlp_cmd_type              cmd;
   nlp_sts_type              sts;

   // Register port: the bias is written on the access phase of a write.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign bias_in    = (csr_write && csr_paddr == BIAS_ADDR) ? $signed(csr_pwdata) : bias_ff;
   assign csr_prdata = (csr_paddr == BIAS_ADDR) ? DATA_W'(bias_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
      end else begin
         bias_ff <= bias_in;
      end
   end

   nlp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   nlp_datapath #(
      .MAX_FEATURES (MAX_FEATURES),
      .FRAC_BITS    (FRAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_entry_index   (req_entry_index),
      .req_feature_value (req_feature_value),
      .req_load_weight   (req_load_weight),
      .req_load_mean     (req_load_mean),
      .req_load_scale    (req_load_scale),
      .req_last          (req_last),
      .bias              (bias_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_prediction    (rsp_prediction),
      .rsp_features_used (rsp_features_used),
      .rsp_too_many      (rsp_too_many),
      .rsp_saturated     (rsp_saturated)
   );

endmodule

// ===== tb/tb_normalized_linear_predictor.sv =====
`timescale 1ns / 1ps

module tb_normalized_linear_predictor;
   import nlp_pkg::*;

   localparam int MAX_FEATURES = DEF_MAX_FEATURES;
   localparam int FRAC_BITS    = DEF_FRAC_BITS;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SETTLE_CYCLES = 100;
   localparam logic [1:0] BIAS_ADDR = 2'd0;

   localparam longint SUM_HI  = (longint'(1) <<< (SUM_W - 1)) - 1;
   localparam longint SUM_LO  = -SUM_HI - 1;
   localparam longint TERM_HI = 2 * SUM_HI;
   localparam longint TERM_LO = 2 * SUM_LO;
   localparam longint ONE_Q   = longint'(1) <<< FRAC_BITS;

   typedef struct packed {
      logic               kind;
      logic [INDEX_W-1:0] entry_index;
      logic [DATA_W-1:0]  feature_value;
      logic [DATA_W-1:0]  load_weight;
      logic [DATA_W-1:0]  load_mean;
      logic [SCALE_W-1:0] load_scale;
      logic               last;
   } req_word_type;

   typedef struct packed {
      logic [PRED_W-1:0] prediction;
      logic [USED_W-1:0] features_used;
      logic              too_many;
      logic              saturated;
   } prediction_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_kind = 1'b0;
   logic [INDEX_W-1:0]        req_entry_index = '0;
   logic signed [DATA_W-1:0]  req_feature_value = '0;
   logic signed [DATA_W-1:0]  req_load_weight = '0;
   logic signed [DATA_W-1:0]  req_load_mean = '0;
   logic [SCALE_W-1:0]        req_load_scale = '0;
   logic                      req_last = 1'b0;

   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [PRED_W-1:0]  rsp_prediction;
   logic [USED_W-1:0]         rsp_features_used;
   logic                      rsp_too_many;
   logic                      rsp_saturated;

   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [1:0]                csr_paddr = '0;
   logic [DATA_W-1:0]         csr_pwdata = '0;
   logic [DATA_W-1:0]         csr_prdata;
   logic                      csr_pready;

   normalized_linear_predictor dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_entry_index   (req_entry_index),
      .req_feature_value (req_feature_value),
      .req_load_weight   (req_load_weight),
      .req_load_mean     (req_load_mean),
      .req_load_scale    (req_load_scale),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_prediction    (rsp_prediction),
      .rsp_features_used (rsp_features_used),
      .rsp_too_many      (rsp_too_many),
      .rsp_saturated     (rsp_saturated),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #5 clock = ~clock;

   // Words waiting to be driven and predictions waiting for their result.
   req_word_type   request_words_q [$];
   prediction_type due_predictions_q [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int result_count = 0;
   int cycle_count = 0;
   logic word_taken = 1'b0;

   // Predictor state: coefficient table, bias and the running vector.
   logic [DATA_W-1:0]  coef_weight [MAX_FEATURES];
   logic [DATA_W-1:0]  coef_mean [MAX_FEATURES];
   logic [SCALE_W-1:0] coef_scale [MAX_FEATURES];
   logic [DATA_W-1:0]  bias_value = '0;
   longint             vec_sum = 0;
   int                 vec_pos = 0;
   logic               vec_overflow = 1'b0;
   logic               vec_saturated = 1'b0;

   // Generator bookkeeping, so that no feature ever reads an unloaded entry.
   bit gen_written [MAX_FEATURES];
   int gen_prefix = 0;
   int gen_count = 0;

   task automatic report_mismatch(input string what);
      $display("mismatch (result %0d): %s", result_count, what);
      error_count++;
   endtask

   // Applies one accepted word to the predictor state; a last feature yields a prediction.
   task automatic score_word(input req_word_type w);
      longint acc;
      longint x;
      longint wt;
      longint mn;
      longint sc;
      longint prod;
      longint term;
      prediction_type res;
      if (w.kind == KIND_LOAD) begin
         coef_weight[w.entry_index] = w.load_weight;
         coef_mean[w.entry_index]   = w.load_mean;
         coef_scale[w.entry_index]  = w.load_scale;
      end else begin
         acc = vec_sum;
         if (vec_pos == 0 && !vec_overflow) begin
            acc = longint'($signed(bias_value));
         end
         if (vec_pos < MAX_FEATURES) begin
            x  = longint'($signed(w.feature_value));
            wt = longint'($signed(coef_weight[vec_pos]));
            mn = longint'($signed(coef_mean[vec_pos]));
            sc = longint'({1'b0, coef_scale[vec_pos]});
            if (sc == 0) begin
               sc = ONE_Q;
            end
            prod = wt * (x - mn);
            term = prod / sc;
            if (term > TERM_HI) begin
               term = TERM_HI;
            end else if (term < TERM_LO) begin
               term = TERM_LO;
            end
            acc = acc + term;
            if (acc > SUM_HI) begin
               acc = SUM_HI;
               vec_saturated = 1'b1;
            end else if (acc < SUM_LO) begin
               acc = SUM_LO;
               vec_saturated = 1'b1;
            end
            vec_pos++;
         end else begin
            // Features beyond the table are dropped but remembered.
            vec_overflow = 1'b1;
         end
         vec_sum = acc;
         if (w.last) begin
            if (acc > ONE_Q) begin
               acc = ONE_Q;
            end else if (acc < -ONE_Q) begin
               acc = -ONE_Q;
            end
            res.prediction    = acc[PRED_W-1:0];
            res.features_used = vec_pos[USED_W-1:0];
            res.too_many      = vec_overflow;
            res.saturated     = vec_saturated;
            due_predictions_q.insert(due_predictions_q.size(), res);
            vec_sum       = 0;
            vec_pos       = 0;
            vec_overflow  = 1'b0;
            vec_saturated = 1'b0;
         end
      end
   endtask

   // A word is taken at the rising edge at which valid and ready are both high.
   always @(posedge clock) begin : word_accept
      req_word_type w;
      if (!reset && req_valid && req_ready) begin
         w = request_words_q.pop_front();
         score_word(w);
         word_taken = 1'b1;
      end
   end

   // The next word is presented at the falling edge, with random gaps.
   always @(negedge clock) begin : word_drive
      req_word_type head;
      if (!req_valid || word_taken) begin
         if (request_words_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            head = request_words_q[0];
            req_kind          <= head.kind;
            req_entry_index   <= head.entry_index;
            req_feature_value <= head.feature_value;
            req_load_weight   <= head.load_weight;
            req_load_mean     <= head.load_mean;
            req_load_scale    <= head.load_scale;
            req_last          <= head.last;
            req_valid         <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      word_taken = 1'b0;
   end

   // The receiver stalls at random.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Each result word is compared with the oldest prediction.
   always @(posedge clock) begin : result_check
      prediction_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_predictions_q.size() == 0) begin
            report_mismatch("result word with no prediction waiting");
         end else begin
            due = due_predictions_q.pop_front();
            if (rsp_prediction !== due.prediction) begin
               report_mismatch($sformatf("prediction %0d, expected %0d",
                  rsp_prediction, $signed(due.prediction)));
            end
            if (rsp_features_used !== due.features_used) begin
               report_mismatch($sformatf("features_used %0d, expected %0d",
                  rsp_features_used, due.features_used));
            end
            if (rsp_too_many !== due.too_many) begin
               report_mismatch($sformatf("too_many %b, expected %b",
                  rsp_too_many, due.too_many));
            end
            if (rsp_saturated !== due.saturated) begin
               report_mismatch($sformatf("saturated %b, expected %b",
                  rsp_saturated, due.saturated));
            end
         end
         result_count++;
      end
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_normalized_linear_predictor: done, errors");
         $finish;
      end
   end

   // Writes the bias register, then reads it back.
   task automatic write_bias(input logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= BIAS_ADDR;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      bias_value = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_psel <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value) begin
         report_mismatch($sformatf("bias read back %h, written %h", csr_prdata, value));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Waits until every word is taken and every prediction has been met.
   task automatic drain_and_settle();
      while (request_words_q.size() != 0 || req_valid) @(posedge clock);
      while (due_predictions_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Q15.16 values: mostly around unity, some full range, some extremes.
   function automatic logic [DATA_W-1:0] rand_q16();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5) return 32'h8000_0000;
      if (r < 10) return 32'h7FFF_FFFF;
      if (r < 15) return 32'h0000_0000;
      if (r < 40) return $urandom();
      return $urandom_range(0, 131071) - 32'd65536;
   endfunction

   function automatic logic [SCALE_W-1:0] rand_scale();
      int unsigned r;
      logic [SCALE_W-1:0] s;
      r = $urandom_range(0, 99);
      if (r < 5) return 31'd1;
      if (r < 10) return 31'h7FFF_FFFF;
      if (r < 30) begin
         s = SCALE_W'($urandom());
         return (s == 0) ? 31'd1 : s;
      end
      return SCALE_W'($urandom_range(16384, 262144));
   endfunction

   task automatic push_load(input int idx, input logic [DATA_W-1:0] weight,
                            input logic [DATA_W-1:0] mean, input logic [SCALE_W-1:0] scale,
                            input logic lst);
      req_word_type w;
      w.kind          = KIND_LOAD;
      w.entry_index   = INDEX_W'(idx);
      w.feature_value = $urandom();
      w.load_weight   = weight;
      w.load_mean     = mean;
      w.load_scale    = scale;
      w.last          = lst;
      request_words_q.insert(request_words_q.size(), w);
      gen_written[idx] = 1'b1;
      while (gen_prefix < MAX_FEATURES && gen_written[gen_prefix]) gen_prefix++;
      gen_count++;
   endtask

   task automatic push_random_load(input int idx, input logic lst);
      push_load(idx, rand_q16(), rand_q16(), rand_scale(), lst);
   endtask

   task automatic push_feature(input logic [DATA_W-1:0] value, input logic lst);
      req_word_type w;
      w.kind          = KIND_FEATURE;
      w.entry_index   = INDEX_W'($urandom_range(0, MAX_FEATURES - 1));
      w.feature_value = value;
      w.load_weight   = $urandom();
      w.load_mean     = $urandom();
      w.load_scale    = SCALE_W'($urandom());
      w.last          = lst;
      request_words_q.insert(request_words_q.size(), w);
      gen_count++;
   endtask

   // One vector of random features, now and then with a load slipped in between.
   task automatic push_vector(input int len);
      int k;
      for (k = 0; k < len; k++) begin
         if ($urandom_range(0, 99) < 4) begin
            push_random_load($urandom_range(0, MAX_FEATURES - 1), 1'b0);
         end
         push_feature(rand_q16(), k == len - 1);
      end
   endtask

   // Random traffic: table growth, reloads, stray loads and vectors over the loaded prefix.
   task automatic fill_random(input int n);
      int target;
      int r;
      int len;
      target = gen_count + n;
      while (gen_count < target) begin
         r = $urandom_range(0, 99);
         if (r < 15 || gen_prefix == 0) begin
            len = $urandom_range(1, 24);
            repeat (len) begin
               if (gen_prefix < MAX_FEATURES) begin
                  push_random_load(gen_prefix, 1'($urandom_range(0, 1)));
               end
            end
         end else if (r < 25) begin
            push_random_load($urandom_range(0, MAX_FEATURES - 1), 1'($urandom_range(0, 1)));
         end else begin
            if ($urandom_range(0, 19) == 0) begin
               len = $urandom_range(1, gen_prefix);
            end else begin
               len = $urandom_range(1, (gen_prefix < 8) ? gen_prefix : 8);
            end
            push_vector(len);
         end
      end
   endtask

   initial begin : stimulus
      int idx;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, bias of a quarter.
      send_idle_pct = 28;
      recv_idle_pct = 68;
      write_bias(32'h0000_4000);
      push_load(0, 32'h0001_0000, 32'h0000_0000, 31'h0001_0000, 1'b0);
      push_load(1, 32'h7FFF_FFFF, 32'h8000_0000, 31'd1, 1'b0);
      push_load(2, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
      push_load(3, 32'hFFFF_0000, 32'h0000_8000, 31'h0002_0000, 1'b0);
      // A single-feature vector inside the clamp range.
      push_feature(32'h0000_8000, 1'b1);
      // Positive saturation, clamped to plus one.
      push_feature(32'h0002_0000, 1'b0);
      push_feature(32'h7FFF_FFFF, 1'b0);
      push_feature(32'h8000_0000, 1'b0);
      push_feature(32'h0000_0000, 1'b1);
      // A load in the middle of a vector drives the sum to negative saturation.
      push_feature(32'h8000_0000, 1'b0);
      push_load(1, 32'h8000_0000, 32'h8000_0000, 31'd1, 1'b0);
      push_feature(32'h7FFF_FFFF, 1'b0);
      push_feature(32'h0001_0000, 1'b1);
      // Last on a load word is ignored.
      push_load(4, 32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF, 1'b1);
      push_feature(32'hFFFF_C000, 1'b1);
      push_feature(32'h7FFF_FFFF, 1'b0);
      push_feature(32'h8000_0000, 1'b0);
      push_feature(32'h0000_0000, 1'b0);
      push_feature(32'hFFFF_FFFF, 1'b0);
      push_feature(32'h1234_5678, 1'b1);
      drain_and_settle();

      // Random phase at the most negative bias.
      write_bias(32'h8000_0000);
      fill_random(80);
      drain_and_settle();

      // Random phase at the most positive bias, idling swapped.
      send_idle_pct = 68;
      recv_idle_pct = 28;
      write_bias(32'h7FFF_FFFF);
      fill_random(80);
      drain_and_settle();

      // Random phase at a small bias with no idling, then a vector longer than the table.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_bias($urandom_range(0, 131071) - 32'd65536);
      fill_random(80);
      for (idx = 0; idx < MAX_FEATURES; idx++) begin
         if (!gen_written[idx]) begin
            push_random_load(idx, 1'b0);
         end
      end
      push_vector(MAX_FEATURES + 3);
      push_vector(3);
      drain_and_settle();

      if (error_count == 0) begin
         $display("tb_normalized_linear_predictor: done, clean");
      end else begin
         $display("tb_normalized_linear_predictor: done, errors");
      end
      $finish;
   end

endmodule

// ===== normalized_linear_predictor.f =====
src/nlp_pkg.sv
src/nlp_divider.sv
src/nlp_datapath.sv
src/nlp_ctrl.sv
src/normalized_linear_predictor.sv
tb/tb_normalized_linear_predictor.sv
